// ----- hdl/light_level_conditioner_defines.svh -----
// Assertion macros for the light level conditioner checker.
// Standalone header: needs nothing else, expects aclk and aresetn in scope.
`ifndef LIGHT_LEVEL_CONDITIONER_DEFINES_SVH
`define LIGHT_LEVEL_CONDITIONER_DEFINES_SVH

// same-cycle implication
`define LLC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LLC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/llc_pkg.sv -----
// Shared constants, codes and controller/datapath interface types
// for the light level conditioner. No dependencies.
package llc_pkg;

    localparam int WINDOW_LEN       = 5;
    localparam int SAMPLE_PERIOD_MS = 10;

    localparam int PTR_W    = $clog2(WINDOW_LEN);
    localparam int RANK_W   = $clog2(WINDOW_LEN);
    localparam int MED_RANK = WINDOW_LEN / 2;

    localparam int ADC_W      = 12;
    localparam int LEVEL_W    = 7;
    localparam int EMA_W      = 10;
    localparam int NORM_W     = 10;
    localparam int RATE_W     = 16;
    localparam int DIFF_W     = 10;
    localparam int CAL_W      = 7;
    localparam int THR_W      = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam int ADC_CLAMP   = 4000;
    localparam int LEVEL_TOP   = 100;
    localparam int EMA_MAX     = 1000;
    localparam int EMA_ROUND   = 5;
    localparam int NORM_MAX    = 1000;
    localparam int NUM_SCALE   = 1000;
    localparam int DIFF_LIMIT  = 320;
    localparam int RATE_SCALE  = 1000 / SAMPLE_PERIOD_MS;

    // reciprocal multipliers: x/5 = (x*205)>>10 for x<512, 3x/10 = (x*9831)>>15,
    // x/10 = (x*205)>>11 for x<=1005
    localparam int RECIP5_MUL   = 205;
    localparam int RECIP5_SHIFT = 10;
    localparam int EMA_MUL      = 9831;
    localparam int EMA_SHIFT    = 15;
    localparam int RECIP10_MUL  = 205;
    localparam int RECIP10_SHIFT = 11;

    localparam int DIV_W     = 17;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_PRIME = 1'b1
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CALIB_LOW  = 2'd0,
        CFG_CALIB_HIGH = 2'd1,
        CFG_HAND_ON    = 2'd2,
        CFG_HAND_OFF   = 2'd3
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LEVEL,
        ST_PRIME,
        ST_WIN,
        ST_MED,
        ST_EMA_MUL,
        ST_EMA_UPD,
        ST_FILT,
        ST_NUM,
        ST_DIV,
        ST_NORM,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic load_in;
        logic calc_level;
        logic prime_wr;
        logic win_wr;
        logic calc_med;
        logic ema_mul;
        logic ema_upd;
        logic calc_filt;
        logic calc_num;
        logic div_step;
        logic calc_norm;
        logic finish;
    } llc_cmd_t;

    typedef struct packed {
        logic is_prime;
        logic div_done;
        logic out_free;
    } llc_sts_t;

endpackage

// ----- hdl/llc_ctrl.sv -----
// Sequencing state machine for the light level conditioner.
// Depends on llc_pkg; drives llc_datapath through llc_cmd_t.
module llc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  llc_pkg::llc_sts_t sts,
    output llc_pkg::llc_cmd_t cmd
);

    llc_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= llc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            llc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = llc_pkg::ST_LEVEL;
                end
            end
            llc_pkg::ST_LEVEL: begin
                cmd.calc_level = 1'b1;
                state_next = sts.is_prime ? llc_pkg::ST_PRIME : llc_pkg::ST_WIN;
            end
            llc_pkg::ST_PRIME: begin
                if (sts.out_free) begin
                    cmd.prime_wr = 1'b1;
                    state_next   = llc_pkg::ST_IDLE;
                end
            end
            llc_pkg::ST_WIN: begin
                cmd.win_wr = 1'b1;
                state_next = llc_pkg::ST_MED;
            end
            llc_pkg::ST_MED: begin
                cmd.calc_med = 1'b1;
                state_next   = llc_pkg::ST_EMA_MUL;
            end
            llc_pkg::ST_EMA_MUL: begin
                cmd.ema_mul = 1'b1;
                state_next  = llc_pkg::ST_EMA_UPD;
            end
            llc_pkg::ST_EMA_UPD: begin
                cmd.ema_upd = 1'b1;
                state_next  = llc_pkg::ST_FILT;
            end
            llc_pkg::ST_FILT: begin
                cmd.calc_filt = 1'b1;
                state_next    = llc_pkg::ST_NUM;
            end
            llc_pkg::ST_NUM: begin
                cmd.calc_num = 1'b1;
                state_next   = llc_pkg::ST_DIV;
            end
            llc_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_done) begin
                    state_next = llc_pkg::ST_NORM;
                end
            end
            llc_pkg::ST_NORM: begin
                cmd.calc_norm = 1'b1;
                state_next    = llc_pkg::ST_FIN;
            end
            llc_pkg::ST_FIN: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = llc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = llc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/llc_datapath.sv -----
// Datapath of the light level conditioner: config registers, window,
// median, EMA, restoring divider, rate, hysteresis, output register. Uses llc_pkg.
module llc_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  llc_pkg::llc_cmd_t                    cmd,
    output llc_pkg::llc_sts_t                    sts,
    input  logic                                 s_opcode,
    input  logic [llc_pkg::ADC_W-1:0]            s_adc_sample,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [llc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [llc_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [llc_pkg::LEVEL_W-1:0]          m_filtered_level,
    output logic [llc_pkg::NORM_W-1:0]           m_norm_level,
    output logic signed [llc_pkg::RATE_W-1:0]    m_change_rate,
    output logic                                 m_hand_present
);

    // config
    logic [llc_pkg::CAL_W-1:0] cal_low_reg, cal_high_reg;
    logic [llc_pkg::THR_W-1:0] hand_on_reg, hand_off_reg;

    // input capture and level
    logic                        op_reg;
    logic [llc_pkg::ADC_W-1:0]   adc_reg;
    logic [llc_pkg::ADC_W-1:0]   adc_clamp;
    logic [16:0]                 lvl_prod;
    logic [llc_pkg::LEVEL_W-1:0] level_next, level_reg;

    // window and median
    logic [llc_pkg::LEVEL_W-1:0] win_reg [llc_pkg::WINDOW_LEN];
    logic [llc_pkg::PTR_W-1:0]   ptr_reg;
    logic [llc_pkg::RANK_W-1:0]  rank [llc_pkg::WINDOW_LEN];
    logic [llc_pkg::LEVEL_W-1:0] med_next, med_reg;

    // EMA
    logic [llc_pkg::EMA_W-1:0]   ema_reg;
    logic [10:0]                 med10;
    logic signed [11:0]          ema_diff;
    logic [10:0]                 diff_abs;
    logic [24:0]                 ema_prod_reg;
    logic                        ema_neg_reg;
    logic [9:0]                  ema_step;
    logic signed [11:0]          ema_sum;
    logic [llc_pkg::EMA_W-1:0]   ema_next;
    logic [18:0]                 filt_prod;
    logic [llc_pkg::LEVEL_W-1:0] filt_reg;

    // normalization and divider
    logic signed [7:0]            hi_minus;
    logic signed [17:0]           num_val;
    logic [llc_pkg::CAL_W-1:0]    span_next, span_reg;
    logic                         num_pos_reg;
    logic [llc_pkg::CAL_W-1:0]    rem_reg;
    logic [llc_pkg::DIV_W-1:0]    quo_reg;
    logic [llc_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [llc_pkg::CAL_W:0]      trial;
    logic                         trial_ge;
    logic [llc_pkg::NORM_W-1:0]   nv_next, nv_reg;
    logic signed [10:0]           norm_diff;
    logic signed [llc_pkg::DIFF_W-1:0] diff_next, diff_reg;

    // result
    logic [llc_pkg::NORM_W-1:0]    last_norm_reg;
    logic                          hand_reg, hand_mid, hand_next;
    logic signed [16:0]            rate_full;
    logic                          m_valid_reg;
    logic [llc_pkg::LEVEL_W-1:0]   out_filt_reg;
    logic [llc_pkg::NORM_W-1:0]    out_norm_reg;
    logic signed [llc_pkg::RATE_W-1:0] out_rate_reg;
    logic                          out_hand_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_low_reg  <= llc_pkg::CAL_W'(20);
            cal_high_reg <= llc_pkg::CAL_W'(90);
            hand_on_reg  <= llc_pkg::THR_W'(80);
            hand_off_reg <= llc_pkg::THR_W'(40);
        end else if (cfg_valid) begin
            case (llc_pkg::cfg_index_t'(cfg_index))
                llc_pkg::CFG_CALIB_LOW:  cal_low_reg  <= cfg_data[llc_pkg::CAL_W-1:0];
                llc_pkg::CFG_CALIB_HIGH: cal_high_reg <= cfg_data[llc_pkg::CAL_W-1:0];
                llc_pkg::CFG_HAND_ON:    hand_on_reg  <= cfg_data[llc_pkg::THR_W-1:0];
                llc_pkg::CFG_HAND_OFF:   hand_off_reg <= cfg_data[llc_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // level = 100 - min(v,4000)/40, with /40 as >>3 then /5
    assign adc_clamp  = (adc_reg > llc_pkg::ADC_W'(llc_pkg::ADC_CLAMP)) ?
                        llc_pkg::ADC_W'(llc_pkg::ADC_CLAMP) : adc_reg;
    assign lvl_prod   = 17'(adc_clamp[llc_pkg::ADC_W-1:3]) * 17'(llc_pkg::RECIP5_MUL);
    assign level_next = llc_pkg::LEVEL_W'(llc_pkg::LEVEL_TOP) -
                        lvl_prod[llc_pkg::RECIP5_SHIFT +: llc_pkg::LEVEL_W];

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg  <= s_opcode;
            adc_reg <= s_adc_sample;
        end
        if (cmd.calc_level) begin
            level_reg <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < llc_pkg::WINDOW_LEN; i++) begin
                win_reg[i] <= '0;
            end
            ptr_reg <= '0;
        end else if (cmd.prime_wr) begin
            for (int i = 0; i < llc_pkg::WINDOW_LEN; i++) begin
                win_reg[i] <= level_reg;
            end
        end else if (cmd.win_wr) begin
            win_reg[ptr_reg] <= level_reg;
            ptr_reg <= (ptr_reg == llc_pkg::PTR_W'(llc_pkg::WINDOW_LEN - 1)) ?
                       '0 : ptr_reg + 1'b1;
        end
    end

    // median by rank: ties broken by position
    always_comb begin
        med_next = '0;
        for (int i = 0; i < llc_pkg::WINDOW_LEN; i++) begin
            rank[i] = '0;
            for (int j = 0; j < llc_pkg::WINDOW_LEN; j++) begin
                if (j != i) begin
                    if ((win_reg[j] < win_reg[i]) || ((j < i) && (win_reg[j] == win_reg[i]))) begin
                        rank[i] = rank[i] + 1'b1;
                    end
                end
            end
            if (rank[i] == llc_pkg::RANK_W'(llc_pkg::MED_RANK)) begin
                med_next = win_reg[i];
            end
        end
    end

    // ema += trunc(3*(10*med - ema)/10), clamped to 0..1000
    assign med10    = 11'(med_reg) * 11'd10;
    assign ema_diff = $signed({1'b0, med10}) - $signed({2'b00, ema_reg});
    assign diff_abs = ema_diff[11] ? 11'(-ema_diff) : ema_diff[10:0];
    assign ema_step = ema_prod_reg[llc_pkg::EMA_SHIFT +: 10];
    assign ema_sum  = ema_neg_reg ? ($signed({2'b00, ema_reg}) - $signed({2'b00, ema_step}))
                                  : ($signed({2'b00, ema_reg}) + $signed({2'b00, ema_step}));

    always_comb begin
        if (ema_sum < 0) begin
            ema_next = '0;
        end else if (ema_sum > 12'sd1000) begin
            ema_next = llc_pkg::EMA_W'(llc_pkg::EMA_MAX);
        end else begin
            ema_next = ema_sum[llc_pkg::EMA_W-1:0];
        end
    end

    assign filt_prod = 19'(11'(ema_reg) + 11'(llc_pkg::EMA_ROUND)) *
                       19'(llc_pkg::RECIP10_MUL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ema_reg <= '0;
        end else if (cmd.prime_wr) begin
            ema_reg <= llc_pkg::EMA_W'(10'(level_reg) * 10'd10);
        end else if (cmd.ema_upd) begin
            ema_reg <= ema_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.calc_med) begin
            med_reg <= med_next;
        end
        if (cmd.ema_mul) begin
            ema_prod_reg <= 25'(diff_abs) * 25'(llc_pkg::EMA_MUL);
            ema_neg_reg  <= ema_diff[11];
        end
        if (cmd.calc_filt) begin
            filt_reg <= filt_prod[llc_pkg::RECIP10_SHIFT +: llc_pkg::LEVEL_W];
        end
    end

    // norm = (cal_high - filt)*1000 / span, clamped to 0..1000
    assign hi_minus  = $signed({1'b0, cal_high_reg}) - $signed({1'b0, filt_reg});
    assign num_val   = 18'(hi_minus) * 18'sd1000;
    assign span_next = (cal_high_reg > cal_low_reg) ? (cal_high_reg - cal_low_reg)
                                                    : llc_pkg::CAL_W'(1);
    assign trial     = {rem_reg, quo_reg[llc_pkg::DIV_W-1]};
    assign trial_ge  = (trial >= {1'b0, span_reg});

    always_ff @(posedge aclk) begin
        if (cmd.calc_num) begin
            quo_reg     <= num_val[llc_pkg::DIV_W-1:0];
            num_pos_reg <= (num_val > 0);
            span_reg    <= span_next;
            rem_reg     <= '0;
            cnt_reg     <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= trial_ge ? llc_pkg::CAL_W'(trial - {1'b0, span_reg})
                                : trial[llc_pkg::CAL_W-1:0];
            quo_reg <= {quo_reg[llc_pkg::DIV_W-2:0], trial_ge};
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_comb begin
        if (!num_pos_reg) begin
            nv_next = '0;
        end else if (quo_reg > llc_pkg::DIV_W'(llc_pkg::NORM_MAX)) begin
            nv_next = llc_pkg::NORM_W'(llc_pkg::NORM_MAX);
        end else begin
            nv_next = quo_reg[llc_pkg::NORM_W-1:0];
        end
    end

    assign norm_diff = $signed({1'b0, nv_next}) - $signed({1'b0, last_norm_reg});

    always_comb begin
        if (norm_diff > 11'sd320) begin
            diff_next = llc_pkg::DIFF_W'(llc_pkg::DIFF_LIMIT);
        end else if (norm_diff < -11'sd320) begin
            diff_next = -llc_pkg::DIFF_W'(llc_pkg::DIFF_LIMIT);
        end else begin
            diff_next = norm_diff[llc_pkg::DIFF_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.calc_norm) begin
            nv_reg   <= nv_next;
            diff_reg <= diff_next;
        end
    end

    assign rate_full = 17'(diff_reg) * $signed(17'(llc_pkg::RATE_SCALE));
    assign hand_mid  = hand_reg | (nv_reg > hand_on_reg);
    assign hand_next = hand_mid & ~(nv_reg < hand_off_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_norm_reg <= '0;
            hand_reg      <= 1'b0;
        end else if (cmd.finish) begin
            last_norm_reg <= nv_reg;
            hand_reg      <= hand_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.prime_wr || cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.prime_wr) begin
            out_filt_reg <= level_reg;
            out_norm_reg <= last_norm_reg;
            out_rate_reg <= '0;
            out_hand_reg <= hand_reg;
        end else if (cmd.finish) begin
            out_filt_reg <= filt_reg;
            out_norm_reg <= nv_reg;
            out_rate_reg <= rate_full[llc_pkg::RATE_W-1:0];
            out_hand_reg <= hand_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_filtered_level = out_filt_reg;
    assign m_norm_level     = out_norm_reg;
    assign m_change_rate    = out_rate_reg;
    assign m_hand_present   = out_hand_reg;

    assign sts.is_prime = (op_reg == llc_pkg::OP_PRIME);
    assign sts.div_done = (cnt_reg == llc_pkg::DIV_CNT_W'(llc_pkg::DIV_W - 1));
    assign sts.out_free = ~m_valid_reg | m_ready;

endmodule

// ----- hdl/light_level_conditioner.sv -----
// Tick: the input transaction runs through level, window, median, EMA, filter and
// numerator steps, a restoring divider by the calibration span, then norm and finish;
// prime: level, then prime write; plus any output stall. Only one transaction is in
// flight; a finished result waits in the output register while the next input is taken.
// Reset (aresetn low, synchronous): window, pointer, EMA, last norm, hand flag cleared,
// config to 20/90/80/40, no result pending.
module light_level_conditioner (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_opcode,
    input  logic [llc_pkg::ADC_W-1:0]            s_adc_sample,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [llc_pkg::LEVEL_W-1:0]          m_filtered_level,
    output logic [llc_pkg::NORM_W-1:0]           m_norm_level,
    output logic signed [llc_pkg::RATE_W-1:0]    m_change_rate,
    output logic                                 m_hand_present,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [llc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [llc_pkg::CFG_DATA_W-1:0]       cfg_data
);

    llc_pkg::llc_cmd_t cmd;
    llc_pkg::llc_sts_t sts;

    llc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    llc_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .s_opcode         (s_opcode),
        .s_adc_sample     (s_adc_sample),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_filtered_level (m_filtered_level),
        .m_norm_level     (m_norm_level),
        .m_change_rate    (m_change_rate),
        .m_hand_present   (m_hand_present)
    );

endmodule

// ----- hdl/llc_checker.sv -----
// Port-level assertion checker for light_level_conditioner, bound to the top level.
// Depends on llc_pkg and light_level_conditioner_defines.svh.
`include "light_level_conditioner_defines.svh"

module llc_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [llc_pkg::LEVEL_W-1:0]       m_filtered_level,
    input logic [llc_pkg::NORM_W-1:0]        m_norm_level,
    input logic signed [llc_pkg::RATE_W-1:0] m_change_rate,
    input logic                              m_hand_present
);

    `LLC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_norm_level) && $stable(m_change_rate) && $stable(m_hand_present), "result changed while stalled")
    `LLC_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready, "second transaction taken while busy")
    `LLC_ASSERT_IMP(a_level_range, m_valid, (m_filtered_level <= 7'd100) && (m_norm_level <= 10'd1000), "level out of range")
    `LLC_ASSERT_IMP(a_rate_range, m_valid, (m_change_rate >= -16'sd32000) && (m_change_rate <= 16'sd32000), "rate out of range")

endmodule

bind light_level_conditioner llc_checker u_llc_checker (.*);
